FILE: rtl/core/cdwq_pkg.sv
`default_nettype none

package cdwq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int N_W             = $clog2(MAX_RESULTS + 1);
    localparam int WORD_W          = 32;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_DRAIN   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_CANCEL  = 2'd1,
        KIND_ENTRY   = 2'd2,
        KIND_MARKER  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_CAN_RD,
        ST_CAN_CHK,
        ST_CAN_REPLY,
        ST_DRN_RD,
        ST_DRN_CHK,
        ST_DRN_FLUSH
    } state_t;

    typedef struct packed {
        logic              cancelled;
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] action;
        logic [WORD_W-1:0] ctx;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

FILE: rtl/core/cdwq_ram.sv
`default_nettype none

module cdwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cancellable_deferred_work_queue.sv
`default_nettype none
// Requests are handled one at a time; cmd_stall is high until the current one is finished.
// Enqueue: the reply is loaded in ST_ENQ once the output register is free.
// Cancel: each entry examined is read in ST_CAN_RD and checked in ST_CAN_CHK.
// Drain: pops via ST_DRN_RD and ST_DRN_CHK; each result waits for a free output register.
// An asynchronous low rst_n empties the queue and sets the next handle to one.
// Entry memory contents are not cleared by reset.

module cancellable_deferred_work_queue #(
    parameter int QUEUE_DEPTH = cdwq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_stall,
    input  wire logic [1:0]                  opcode,
    input  wire logic [cdwq_pkg::WORD_W-1:0] action_code,
    input  wire logic [cdwq_pkg::WORD_W-1:0] context_word,
    input  wire logic [cdwq_pkg::WORD_W-1:0] cancel_handle,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output logic [1:0]                       result_kind,
    output logic [cdwq_pkg::WORD_W-1:0]      handle,
    output logic [cdwq_pkg::WORD_W-1:0]      action_code_out,
    output logic [cdwq_pkg::WORD_W-1:0]      context_out,
    output logic                             ok,
    output logic                             last
);

    import cdwq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [WORD_W-1:0]  next_handle_reg, next_handle_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               found_reg, found_next;
    logic               pend_valid_reg, pend_valid_next;
    entry_t             pend_reg, pend_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [WORD_W-1:0]  act_reg, act_next;
    logic [WORD_W-1:0]  ctx_reg, ctx_next;
    logic [WORD_W-1:0]  ch_reg, ch_next;

    logic               res_valid_reg, res_valid_next;
    kind_t              res_kind_reg, res_kind_next;
    logic [WORD_W-1:0]  res_handle_reg, res_handle_next;
    logic [WORD_W-1:0]  res_action_reg, res_action_next;
    logic [WORD_W-1:0]  res_ctx_reg, res_ctx_next;
    logic               res_ok_reg, res_ok_next;
    logic               res_last_reg, res_last_next;

    logic               out_free;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    entry_t             rd_data;
    logic [ENTRY_W-1:0] rd_bits;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    cdwq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    assign rd_data  = entry_t'(rd_bits);
    assign out_free = !res_valid_reg || !res_stall;
    assign rd_en    = (state_reg == ST_CAN_RD) || (state_reg == ST_DRN_RD);
    assign rd_addr  = (state_reg == ST_CAN_RD) ? ptr_reg : head_reg;

    assign cmd_stall       = (state_reg != ST_IDLE);
    assign res_valid       = res_valid_reg;
    assign result_kind     = res_kind_reg;
    assign handle          = res_handle_reg;
    assign action_code_out = res_action_reg;
    assign context_out     = res_ctx_reg;
    assign ok              = res_ok_reg;
    assign last            = res_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        next_handle_next = next_handle_reg;
        ptr_next         = ptr_reg;
        scan_next        = scan_reg;
        found_next       = found_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        n_next           = n_reg;
        act_next         = act_reg;
        ctx_next         = ctx_reg;
        ch_next          = ch_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_kind_next    = res_kind_reg;
        res_handle_next  = res_handle_reg;
        res_action_next  = res_action_reg;
        res_ctx_next     = res_ctx_reg;
        res_ok_next      = res_ok_reg;
        res_last_next    = res_last_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_reg;
        wr_data          = '{cancelled: 1'b0, handle: next_handle_reg,
                             action: act_reg, ctx: ctx_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                act_next        = action_code;
                ctx_next        = context_word;
                ch_next         = cancel_handle;
                ptr_next        = head_reg;
                scan_next       = '0;
                found_next      = 1'b0;
                pend_valid_next = 1'b0;
                n_next          = '0;
                if (cmd_valid)
                begin
                    unique case (op_t'(opcode))
                        OP_ENQUEUE:
                        begin
                            state_next = ST_ENQ;
                        end
                        OP_CANCEL:
                        begin
                            if (cancel_handle == '0 || count_reg == '0)
                            begin
                                state_next = ST_CAN_REPLY;
                            end
                            else
                            begin
                                state_next = ST_CAN_RD;
                            end
                        end
                        OP_DRAIN:
                        begin
                            state_next = (count_reg == '0) ? ST_DRN_FLUSH : ST_DRN_RD;
                        end
                        OP_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ENQ:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_kind_next   = KIND_ENQUEUE;
                    res_action_next = '0;
                    res_ctx_next    = '0;
                    res_last_next   = 1'b1;
                    if (act_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        res_handle_next = '0;
                        res_ok_next     = 1'b0;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        res_handle_next  = next_handle_reg;
                        res_ok_next      = 1'b1;
                        tail_next        = ptr_inc(tail_reg);
                        count_next       = count_reg + CNT_W'(1);
                        next_handle_next = (next_handle_reg == '1) ? WORD_W'(1)
                                                                   : next_handle_reg + WORD_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_CAN_RD:
            begin
                state_next = ST_CAN_CHK;
            end

            ST_CAN_CHK:
            begin
                if (rd_data.handle == ch_reg && !rd_data.cancelled)
                begin
                    wr_en             = 1'b1;
                    wr_addr           = ptr_reg;
                    wr_data           = rd_data;
                    wr_data.cancelled = 1'b1;
                    found_next        = 1'b1;
                    state_next        = ST_CAN_REPLY;
                end
                else if (scan_reg + CNT_W'(1) == count_reg)
                begin
                    state_next = ST_CAN_REPLY;
                end
                else
                begin
                    scan_next  = scan_reg + CNT_W'(1);
                    ptr_next   = ptr_inc(ptr_reg);
                    state_next = ST_CAN_RD;
                end
            end

            ST_CAN_REPLY:
            begin
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_kind_next   = KIND_CANCEL;
                    res_handle_next = '0;
                    res_action_next = '0;
                    res_ctx_next    = '0;
                    res_ok_next     = found_reg;
                    res_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_DRN_RD:
            begin
                state_next = ST_DRN_CHK;
            end

            ST_DRN_CHK:
            begin
                if (rd_data.cancelled || !pend_valid_reg || out_free)
                begin
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - CNT_W'(1);
                    if (!rd_data.cancelled)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_next  = 1'b1;
                            res_kind_next   = KIND_ENTRY;
                            res_handle_next = pend_reg.handle;
                            res_action_next = pend_reg.action;
                            res_ctx_next    = pend_reg.ctx;
                            res_ok_next     = 1'b1;
                            res_last_next   = 1'b0;
                        end
                        pend_next       = rd_data;
                        pend_valid_next = 1'b1;
                        n_next          = n_reg + N_W'(1);
                    end
                    if (count_reg != CNT_W'(1) && n_next != N_W'(MAX_RESULTS))
                    begin
                        state_next = ST_DRN_RD;
                    end
                    else
                    begin
                        state_next = ST_DRN_FLUSH;
                    end
                end
            end

            ST_DRN_FLUSH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_kind_next   = KIND_ENTRY;
                        res_handle_next = pend_reg.handle;
                        res_action_next = pend_reg.action;
                        res_ctx_next    = pend_reg.ctx;
                        res_ok_next     = 1'b1;
                    end
                    else
                    begin
                        res_kind_next   = KIND_MARKER;
                        res_handle_next = '0;
                        res_action_next = '0;
                        res_ctx_next    = '0;
                        res_ok_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            next_handle_reg <= WORD_W'(1);
            res_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            found_reg       <= 1'b0;
            scan_reg        <= '0;
            n_reg           <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            next_handle_reg <= next_handle_next;
            res_valid_reg   <= res_valid_next;
            pend_valid_reg  <= pend_valid_next;
            found_reg       <= found_next;
            scan_reg        <= scan_next;
            n_reg           <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pend_reg       <= pend_next;
        act_reg        <= act_next;
        ctx_reg        <= ctx_next;
        ch_reg         <= ch_next;
        res_kind_reg   <= res_kind_next;
        res_handle_reg <= res_handle_next;
        res_action_reg <= res_action_next;
        res_ctx_reg    <= res_ctx_next;
        res_ok_reg     <= res_ok_next;
        res_last_reg   <= res_last_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_handle_reg != '0)
        else $error("next handle is zero");

    a_enq_ok_handle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == KIND_ENQUEUE |-> res_ok_reg == (res_handle_reg != '0))
        else $error("enqueue reply ok disagrees with handle");

    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_kind_reg == KIND_MARKER |-> !res_ok_reg && res_last_reg)
        else $error("drain marker malformed");

    a_pop_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRN_CHK && state_next != ST_DRN_CHK |=>
            count_reg == $past(count_reg) - CNT_W'(1))
        else $error("drain step did not pop one entry");

endmodule

`default_nettype wire
